### rtl/dabl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dabl_pkg;

    localparam int CTX_PORTS = 4;
    localparam int WORD_W    = 24;
    localparam int LOG_W     = 24;

    typedef enum logic [1:0] {
        OP_CELL    = 2'd0,
        OP_BACKOFF = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // one classified item as it sits in the queue
    typedef struct packed {
        op_t                                 op;
        logic [19:0]                         address;
        logic [31:0]                         base_data;
        logic [31:0]                         check_data;
        logic [WORD_W-1:0]                   query_word;
        logic [CTX_PORTS-1:0][WORD_W-1:0]    ctx;
        logic [2:0]                          n_ctx;
    } q_item_t;

    function automatic logic signed [LOG_W-1:0] sat24(input logic signed [32:0] v);
        logic signed [LOG_W-1:0] r;
        if (v > 33'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -33'sd8388608)
            r = 24'sh800000;
        else
            r = v[LOG_W-1:0];
        return r;
    endfunction

    // negated magnitude of a 32-bit log value, saturated
    function automatic logic signed [LOG_W-1:0] neg_mag(input logic [31:0] raw);
        logic signed [32:0] v;
        v = {raw[31], raw};
        if (v > 33'sd0)
            v = -v;
        return sat24(v);
    endfunction

    function automatic logic signed [LOG_W-1:0] add_sat(input logic signed [LOG_W-1:0] a,
                                                        input logic signed [LOG_W-1:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return sat24(s);
    endfunction

endpackage
`default_nettype wire

### rtl/dabl_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dabl_front
    import dabl_pkg::*;
#(
    parameter int TRIE_DEPTH    = 1048576,
    parameter int BACKOFF_DEPTH = 65536,
    parameter int MAX_CONTEXT   = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [207:0]  s_tdata,
    input  wire logic [1:0]    s_tuser,
    input  wire logic          hold,
    output logic               q_valid,
    output q_item_t            q_item,
    input  wire logic          q_pop
);

    localparam int QDEPTH = 4;
    localparam int NMAX   = (MAX_CONTEXT < CTX_PORTS) ? MAX_CONTEXT : CTX_PORTS;
    localparam logic [31:0] TD32 = 32'(TRIE_DEPTH);
    localparam logic [31:0] BD32 = 32'(BACKOFF_DEPTH);

    q_item_t     fifo_mem [QDEPTH];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  cnt_reg, cnt_next;

    q_item_t     in_item;
    logic        accept;
    logic        keep;
    logic        push;
    logic [2:0]  cnt_raw;

    always_comb
    begin
        in_item.op          = op_t'(s_tuser);
        in_item.address     = s_tdata[19:0];
        in_item.base_data   = s_tdata[51:20];
        in_item.check_data  = s_tdata[83:52];
        in_item.query_word  = s_tdata[107:84];
        in_item.ctx[0]      = s_tdata[131:108];
        in_item.ctx[1]      = s_tdata[155:132];
        in_item.ctx[2]      = s_tdata[179:156];
        in_item.ctx[3]      = s_tdata[203:180];
        cnt_raw             = s_tdata[206:204];
        in_item.n_ctx       = (cnt_raw > 3'(NMAX)) ? 3'(NMAX) : cnt_raw;
    end

    // drop no-ops and writes that fall outside their store
    always_comb
    begin
        unique case (in_item.op)
            OP_CELL:    keep = ({12'b0, in_item.address} < TD32);
            OP_BACKOFF: keep = ({12'b0, in_item.address} < BD32);
            OP_QUERY:   keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign s_tready = (cnt_reg != 3'(QDEPTH)) && !hold;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && keep;
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_item   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 2'(push);
        rd_ptr_next = rd_ptr_reg + 2'(q_pop && q_valid);
        cnt_next    = cnt_reg + 3'(push) - 3'(q_pop && q_valid);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 3'(QDEPTH) |-> !push)
        else $error("queue push while full");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && !(q_pop && q_valid) |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("queue count lost a push");

    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        hold |-> !push)
        else $error("item taken during clear");

endmodule
`default_nettype wire

### rtl/dabl_back.sv
`timescale 1ns / 1ps
`default_nettype none
module dabl_back
    import dabl_pkg::*;
#(
    parameter int TRIE_DEPTH    = 1048576,
    parameter int BACKOFF_DEPTH = 65536
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  q_item_t            q_item,
    output logic               q_pop,
    output logic               hold,
    input  wire logic          cfg_valid,
    input  wire logic [23:0]   cfg_data,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,
    output logic [0:0]         m_tuser
);

    localparam int TA = (TRIE_DEPTH > 1) ? $clog2(TRIE_DEPTH) : 1;
    localparam int BA = (BACKOFF_DEPTH > 1) ? $clog2(BACKOFF_DEPTH) : 1;
    localparam logic [31:0] TD32 = 32'(TRIE_DEPTH);
    localparam logic [31:0] BD32 = 32'(BACKOFF_DEPTH);

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b0000000001,
        ST_IDLE     = 10'b0000000010,
        ST_ROOT     = 10'b0000000100,
        ST_NODE     = 10'b0000001000,
        ST_NODE_CHK = 10'b0000010000,
        ST_TERM     = 10'b0000100000,
        ST_LEAF     = 10'b0001000000,
        ST_BOW      = 10'b0010000000,
        ST_UROOT    = 10'b0100000000,
        ST_OUT      = 10'b1000000000
    } state_t;

    // trie cell: check in the high half, base in the low half
    logic [63:0]             trie_mem [TRIE_DEPTH];
    logic signed [LOG_W-1:0] bow_mem  [BACKOFF_DEPTH];
    logic [63:0]             t_rd;
    logic signed [LOG_W-1:0] b_rd;

    logic          t_we, t_re, b_we, b_re;
    logic [TA-1:0] t_wa, t_ra;
    logic [63:0]   t_wd;
    logic [BA-1:0] b_wa, b_ra;
    logic signed [LOG_W-1:0] b_wd;

    state_t                  state_reg, state_next;
    logic [TA-1:0]           clr_reg, clr_next;
    q_item_t                 item_reg, item_next;
    logic [2:0]              lvl_reg, lvl_next;
    logic [31:0]             pos_reg, pos_next;
    logic [31:0]             pbase_reg, pbase_next;
    logic [31:0]             nxt_reg, nxt_next;
    logic [31:0]             term_reg, term_next;
    logic [31:0]             bidx_reg, bidx_next;
    logic                    hit_reg, hit_next;
    logic                    uni_reg, uni_next;
    logic signed [LOG_W-1:0] prob_reg, prob_next;
    logic signed [LOG_W-1:0] bow_reg, bow_next;
    logic signed [LOG_W-1:0] fin_reg, fin_next;
    logic                    unk_reg, unk_next;
    logic signed [LOG_W-1:0] oov_reg;
    logic                    ov_reg, ov_next;
    logic [LOG_W-1:0]        od_reg, od_next;
    logic                    ou_reg, ou_next;

    always_ff @(posedge clk)
    begin
        if (t_we)
            trie_mem[t_wa] <= t_wd;
        if (t_re)
            t_rd <= trie_mem[t_ra];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            bow_mem[b_wa] <= b_wd;
        if (b_re)
            b_rd <= bow_mem[b_ra];
    end

    always_comb
    begin
        logic [31:0] nb;
        logic [31:0] cand;
        logic [31:0] idx;
        logic        fin_go;
        logic        miss;

        state_next = state_reg;
        clr_next   = clr_reg;
        item_next  = item_reg;
        lvl_next   = lvl_reg;
        pos_next   = pos_reg;
        pbase_next = pbase_reg;
        nxt_next   = nxt_reg;
        term_next  = term_reg;
        bidx_next  = bidx_reg;
        hit_next   = hit_reg;
        uni_next   = uni_reg;
        prob_next  = prob_reg;
        bow_next   = bow_reg;
        fin_next   = fin_reg;
        unk_next   = unk_reg;
        ov_next    = ov_reg && !m_tready;
        od_next    = od_reg;
        ou_next    = ou_reg;

        t_we = 1'b0;
        t_wa = '0;
        t_wd = '1;
        t_re = 1'b0;
        t_ra = '0;
        b_we = 1'b0;
        b_wa = '0;
        b_wd = '0;
        b_re = 1'b0;
        b_ra = '0;
        q_pop = 1'b0;

        nb     = '0;
        cand   = '0;
        idx    = '0;
        fin_go = 1'b0;
        miss   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                t_we = 1'b1;
                t_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TA'(TRIE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.op)
                        OP_CELL:
                        begin
                            t_we = 1'b1;
                            t_wa = TA'(q_item.address);
                            t_wd = {q_item.check_data, q_item.base_data};
                        end
                        OP_BACKOFF:
                        begin
                            b_we = 1'b1;
                            b_wa = BA'(q_item.address);
                            b_wd = sat24({q_item.base_data[31], q_item.base_data});
                        end
                        OP_QUERY:
                        begin
                            item_next  = q_item;
                            lvl_next   = '0;
                            pos_next   = '0;
                            hit_next   = 1'b0;
                            uni_next   = 1'b0;
                            bow_next   = '0;
                            t_re       = 1'b1;
                            state_next = ST_ROOT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROOT:
            begin
                pbase_next = t_rd[31:0];
                state_next = ST_NODE;
            end
            ST_NODE:
            begin
                cand = pbase_reg + 32'(item_reg.ctx[lvl_reg[1:0]]);
                if (lvl_reg >= item_reg.n_ctx || cand >= TD32)
                    fin_go = 1'b1;
                else
                begin
                    nxt_next   = cand;
                    t_re       = 1'b1;
                    t_ra       = cand[TA-1:0];
                    state_next = ST_NODE_CHK;
                end
            end
            ST_NODE_CHK:
            begin
                if (t_rd[63:32] != pos_reg)
                    fin_go = 1'b1;
                else
                begin
                    pos_next   = nxt_reg;
                    pbase_next = t_rd[31:0];
                    nb         = t_rd[31:0] + 32'd1;
                    term_next  = nb;
                    if (nb >= TD32)
                    begin
                        lvl_next   = lvl_reg + 3'd1;
                        state_next = ST_NODE;
                    end
                    else
                    begin
                        t_re       = 1'b1;
                        t_ra       = nb[TA-1:0];
                        state_next = ST_TERM;
                    end
                end
            end
            ST_UROOT:
            begin
                nb        = t_rd[31:0] + 32'd1;
                term_next = nb;
                if (nb >= TD32)
                begin
                    fin_next   = oov_reg;
                    unk_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    t_re       = 1'b1;
                    t_ra       = nb[TA-1:0];
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                cand      = t_rd[31:0] + 32'(item_reg.query_word);
                idx       = 32'd0 - t_rd[63:32];
                bidx_next = idx;
                if (cand >= TD32)
                    miss = 1'b1;
                else
                begin
                    t_re       = 1'b1;
                    t_ra       = cand[TA-1:0];
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF:
            begin
                idx = bidx_reg;
                if (t_rd[63:32] == term_reg)
                begin
                    if (uni_reg)
                    begin
                        fin_next   = neg_mag(t_rd[31:0]);
                        unk_next   = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        hit_next   = 1'b1;
                        prob_next  = neg_mag(t_rd[31:0]);
                        bow_next   = '0;
                        lvl_next   = lvl_reg + 3'd1;
                        state_next = ST_NODE;
                    end
                end
                else
                    miss = 1'b1;
            end
            ST_BOW:
            begin
                bow_next   = add_sat(bow_reg, b_rd);
                lvl_next   = lvl_reg + 3'd1;
                state_next = ST_NODE;
            end
            ST_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = add_sat(fin_reg, bow_reg);
                    ou_next    = unk_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // target not below this terminal
        if (miss)
        begin
            if (uni_reg)
            begin
                fin_next   = oov_reg;
                unk_next   = 1'b1;
                state_next = ST_OUT;
            end
            else if (idx < BD32)
            begin
                b_re       = 1'b1;
                b_ra       = idx[BA-1:0];
                state_next = ST_BOW;
            end
            else
            begin
                lvl_next   = lvl_reg + 3'd1;
                state_next = ST_NODE;
            end
        end

        // walk ended: use the deepest hit or fall back to the unigram
        if (fin_go)
        begin
            if (hit_reg)
            begin
                fin_next   = prob_reg;
                unk_next   = 1'b0;
                state_next = ST_OUT;
            end
            else
            begin
                uni_next   = 1'b1;
                t_re       = 1'b1;
                t_ra       = '0;
                state_next = ST_UROOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            oov_reg   <= -24'sd6553600;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            if (cfg_valid)
                oov_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        lvl_reg   <= lvl_next;
        pos_reg   <= pos_next;
        pbase_reg <= pbase_next;
        nxt_reg   <= nxt_next;
        term_reg  <= term_next;
        bidx_reg  <= bidx_next;
        hit_reg   <= hit_next;
        uni_reg   <= uni_next;
        prob_reg  <= prob_next;
        bow_reg   <= bow_next;
        fin_reg   <= fin_next;
        unk_reg   <= unk_next;
        od_reg    <= od_next;
        ou_reg    <= ou_next;
    end

    assign hold     = (state_reg == ST_CLEAR);
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(t_we && t_re))
        else $error("trie write and read in one cycle");

    a_bow_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BOW |-> $past(b_re))
        else $error("backoff add without a read");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_CLEAR |=> state_reg != ST_CLEAR)
        else $error("clear pass restarted");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NODE_CHK |-> lvl_reg < item_reg.n_ctx)
        else $error("walk past the context count");

endmodule
`default_nettype wire

### rtl/double_array_ngram_backoff_lookup.sv
// Writes pass through the front queue and land in their store when the back end pops them,
// one write a cycle while the back end is idle; a query walks each context level by node
// read, node check, terminal read, leaf read and backoff read, then may fall back to the
// unigram, and its result is registered; one query is in work at a time.
// Throughput is set by the single read port of the trie memory in the back end.
// Reset: asynchronous, active low; afterwards the trie is cleared one cell a cycle over
// all TRIE_DEPTH cells, during which no item is taken (configuration writes are).
`timescale 1ns / 1ps
`default_nettype none
module double_array_ngram_backoff_lookup
    import dabl_pkg::*;
#(
    parameter int TRIE_DEPTH    = 1048576,
    parameter int BACKOFF_DEPTH = 65536,
    parameter int MAX_CONTEXT   = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    // input stream
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // address[19:0] base_data[51:20] check_data[83:52] query_word[107:84]
    // context_one[131:108] context_two[155:132] context_three[179:156]
    // context_four[203:180] context_count[206:204], bit 207 zero
    input  wire logic [207:0]  s_tdata,
    // operation[1:0]
    input  wire logic [1:0]    s_tuser,
    // result stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // log_prob[23:0]
    output logic [23:0]        m_tdata,
    // unknown_word[0]
    output logic [0:0]         m_tuser,
    // oov_log_prob write channel
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [23:0]   cfg_data
);

    q_item_t q_item;
    logic    q_valid;
    logic    q_pop;
    logic    hold;

    // register write always completes in one transfer
    assign cfg_ready = 1'b1;

    // front: takes transfers, drops no-ops and stray writes, queues the rest
    dabl_front #(
        .TRIE_DEPTH    (TRIE_DEPTH),
        .BACKOFF_DEPTH (BACKOFF_DEPTH),
        .MAX_CONTEXT   (MAX_CONTEXT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .hold     (hold),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: owns both stores, walks the trie, registers the result
    dabl_back #(
        .TRIE_DEPTH    (TRIE_DEPTH),
        .BACKOFF_DEPTH (BACKOFF_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .hold      (hold),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import dabl_pkg::*;

    localparam int          CELL_COUNT = 1048576;
    localparam int          BOW_COUNT  = 65536;
    localparam int          CTX_LIMIT  = 4;
    localparam logic [31:0] EMPTY_MARK = 32'hFFFF_FFFF;

    typedef struct {
        op_t         op;
        logic [19:0] address;
        logic [31:0] base_data;
        logic [31:0] check_data;
        logic [23:0] query_word;
        logic [23:0] ctx [4];
        logic [2:0]  ctx_count;
    } lm_item_t;

    typedef struct {
        logic [23:0] log_prob;
        logic        unknown;
    } score_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata = '0;
    logic [1:0]   s_tuser = OP_NONE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [23:0]  cfg_data = '0;

    // predictor state: unwritten trie cells read back as empty
    logic [63:0]        trie_mirror [logic [31:0]];
    logic signed [23:0] backoff_mirror [logic [31:0]];
    logic signed [23:0] oov_value = -24'sd6553600;
    score_t             pending_scores [$];

    int  error_count = 0;
    bit  no_idle = 0;
    int  hold_request = 0;

    always #6 clk = ~clk;

    double_array_ngram_backoff_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic logic signed [23:0] sat_q(input longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic logic [63:0] cell_at(input logic [31:0] i);
        return trie_mirror.exists(i) ? trie_mirror[i] : {EMPTY_MARK, EMPTY_MARK};
    endfunction

    function automatic logic [31:0] cell_base(input logic [31:0] i);
        logic [63:0] c;
        c = cell_at(i);
        return c[31:0];
    endfunction

    function automatic logic [31:0] cell_check(input logic [31:0] i);
        logic [63:0] c;
        c = cell_at(i);
        return c[63:32];
    endfunction

    // target lookup below the terminal of a node
    function automatic bit find_target(input logic [31:0] node, input logic [23:0] tgt,
                                       output logic [31:0] term, output longint prob);
        logic [31:0] leaf;
        longint      v;
        term = cell_base(node) + 32'd1;
        prob = 0;
        if (term >= CELL_COUNT)
            return 0;
        leaf = cell_base(term) + {8'd0, tgt};
        if (leaf >= CELL_COUNT || cell_check(leaf) != term)
            return 0;
        v = longint'(signed'(cell_base(leaf)));
        if (v > 0)
            v = -v;
        prob = sat_q(v);
        return 1;
    endfunction

    // walks the context; missing is set when an unwritten backoff entry would be read
    function automatic void score_query(input lm_item_t it, output score_t s,
                                        output longint missing);
        logic [31:0] pos, nxt, term, idx;
        longint      prob, p, bow;
        bit          hit, stop;
        int          n;
        pos = 0; prob = 0; bow = 0; hit = 0; stop = 0; missing = -1;
        n = (it.ctx_count > CTX_LIMIT) ? CTX_LIMIT : int'(it.ctx_count);
        for (int i = 0; i < n; i++) begin
            if (!stop) begin
                nxt = cell_base(pos) + {8'd0, it.ctx[i]};
                if (nxt >= CELL_COUNT || cell_check(nxt) != pos)
                    stop = 1;
                else begin
                    pos = nxt;
                    if (find_target(nxt, it.query_word, term, p)) begin
                        prob = p;
                        hit = 1;
                        bow = 0;
                    end
                    else if (term < CELL_COUNT) begin
                        idx = 32'd0 - cell_check(term);
                        if (idx < BOW_COUNT) begin
                            if (!backoff_mirror.exists(idx))
                                missing = idx;
                            else
                                bow = sat_q(bow + backoff_mirror[idx]);
                        end
                    end
                end
            end
        end
        s.unknown = 1'b0;
        if (hit)
            s.log_prob = sat_q(prob + bow);
        else if (find_target(0, it.query_word, term, p))
            s.log_prob = sat_q(p + bow);
        else begin
            s.log_prob = sat_q(longint'(oov_value) + bow);
            s.unknown = 1'b1;
        end
    endfunction

    function automatic void apply_item(input lm_item_t it);
        score_t s;
        longint missing;
        case (it.op)
            OP_CELL:
                trie_mirror[{12'd0, it.address}] = {it.check_data, it.base_data};
            OP_BACKOFF:
                if (it.address < BOW_COUNT)
                    backoff_mirror[{12'd0, it.address}] =
                        sat_q(longint'(signed'(it.base_data)));
            OP_QUERY:
            begin
                score_query(it, s, missing);
                pending_scores.push_back(s);
            end
            default: ;
        endcase
    endfunction

    // one transfer on the input stream; valid stays high until a gap
    task automatic push_item(input lm_item_t it);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {1'b0, it.ctx_count, it.ctx[3], it.ctx[2], it.ctx[1], it.ctx[0],
                     it.query_word, it.check_data, it.base_data, it.address};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_item(it);
    endtask

    function automatic lm_item_t blank_item(input op_t op);
        lm_item_t it;
        it.op = op;
        it.address = '0;
        it.base_data = '0;
        it.check_data = '0;
        it.query_word = '0;
        for (int i = 0; i < 4; i++)
            it.ctx[i] = '0;
        it.ctx_count = '0;
        return it;
    endfunction

    task automatic write_cell(input logic [19:0] a, input logic [31:0] b, input logic [31:0] c);
        lm_item_t it;
        it = blank_item(OP_CELL);
        it.address = a;
        it.base_data = b;
        it.check_data = c;
        push_item(it);
    endtask

    task automatic write_backoff(input logic [19:0] a, input logic [31:0] v);
        lm_item_t it;
        it = blank_item(OP_BACKOFF);
        it.address = a;
        it.base_data = v;
        push_item(it);
    endtask

    // fills any backoff entry the query would read before it was written
    task automatic send_query(input lm_item_t it);
        score_t s;
        longint missing;
        score_query(it, s, missing);
        while (missing >= 0) begin
            write_backoff(missing[19:0], $urandom_range(0, 1) ? $urandom() :
                          32'($urandom_range(0, 400000)) - 32'd200000);
            score_query(it, s, missing);
        end
        push_item(it);
    endtask

    task automatic query(input logic [23:0] tgt, input logic [2:0] n,
                         input logic [23:0] w1, input logic [23:0] w2,
                         input logic [23:0] w3 = '0, input logic [23:0] w4 = '0);
        lm_item_t it;
        it = blank_item(OP_QUERY);
        it.query_word = tgt;
        it.ctx_count = n;
        it.ctx[0] = w1; it.ctx[1] = w2; it.ctx[2] = w3; it.ctx[3] = w4;
        send_query(it);
    endtask

    task automatic set_oov(input logic [23:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        oov_value = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // idle point for register writes: all scores back, then the longest query time
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // small hand-built trie: root base 10, unigram terminal 11,
    // word 3 -> node 13, word 3,4 -> node 34, target 5 hits at each
    task automatic test_directed();
        lm_item_t it;
        write_backoff(20'd1, 32'h7FFF_FFFF);    // saturates high
        write_backoff(20'd2, 32'h8000_0000);    // saturates low
        write_backoff(20'd3, 32'hFFFF_0000);
        write_backoff(20'd4, 32'h0002_0000);
        write_backoff(20'hFFFFF, 32'd5);        // outside the table
        write_cell(20'd0, 32'd10, 32'hFFFF_FFFF);
        write_cell(20'd11, 32'd20, 32'hFFFF_FFFE);
        write_cell(20'd25, 32'h0005_0000, 32'd11);
        write_cell(20'd13, 32'd30, 32'd0);
        write_cell(20'd31, 32'd40, 32'hFFFF_FFFD);
        write_cell(20'd45, 32'h8000_0000, 32'd31);  // most negative prob
        write_cell(20'd34, 32'd50, 32'd13);
        write_cell(20'd51, 32'd60, 32'hFFFF_FFFC);
        write_cell(20'd65, 32'd0, 32'd51);           // stored zero is a real hit
        write_cell(20'hFFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        it = blank_item(OP_NONE);
        it.address = 20'hABCDE;
        push_item(it);
        query(24'd5, 3'd0, 24'd0, 24'd0);
        query(24'd5, 3'd1, 24'd3, 24'd0);
        query(24'd5, 3'd2, 24'd3, 24'd4);
        query(24'd7, 3'd2, 24'd3, 24'd4);           // miss: backoff sums
        query(24'hFFFFFF, 3'd4, 24'd3, 24'd4, 24'hFFFFFF, 24'hFFFFFF);
        query(24'd5, 3'd7, 24'd3, 24'd4, 24'd1, 24'd2);  // count clamped
        query(24'd9, 3'd1, 24'hFFFFFF, 24'd0);     // first level out of range
        query(24'd3, 3'd2, 24'd3, 24'd9);
    endtask

    function automatic logic [23:0] pick_word();
        return ($urandom_range(0, 9) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 20));
    endfunction

    // random mix over a small address region so walks reach several levels
    task automatic test_random(input int count);
        lm_item_t it;
        int       kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 18) begin
                it = blank_item(OP_CELL);
                it.address = ($urandom_range(0, 15) == 0) ? 20'($urandom())
                                                          : 20'($urandom_range(0, 80));
                case ($urandom_range(0, 4))
                    0:       it.base_data = $urandom();
                    default: it.base_data = $urandom_range(0, 60);
                endcase
                case ($urandom_range(0, 9))
                    0, 1:    it.check_data = $urandom();
                    2, 3, 4: it.check_data = 32'd0 - 32'($urandom_range(0, 8));
                    default: it.check_data = $urandom_range(0, 80);
                endcase
                push_item(it);
            end
            else if (kind < 27) begin
                write_backoff(($urandom_range(0, 5) == 0) ? 20'($urandom())
                                                         : 20'($urandom_range(0, 16)),
                              ($urandom_range(0, 2) == 0) ? $urandom()
                              : 32'($urandom_range(0, 600000)) - 32'd300000);
            end
            else if (kind < 31) begin
                it = blank_item(OP_NONE);
                it.address = 20'($urandom());
                it.base_data = $urandom();
                it.query_word = 24'($urandom());
                push_item(it);
            end
            else begin
                it = blank_item(OP_QUERY);
                it.address = 20'($urandom());
                it.base_data = $urandom();
                it.check_data = $urandom();
                it.query_word = pick_word();
                for (int i = 0; i < 4; i++)
                    it.ctx[i] = pick_word();
                it.ctx_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                           : 3'($urandom_range(1, 4));
                send_query(it);
            end
        end
    endtask

    // result side holds off long enough that the input side stalls
    task automatic test_backpressure();
        hold_request = 300;
        for (int k = 0; k < 30; k++)
            query(pick_word(), 3'($urandom_range(0, 4)), pick_word(), pick_word(),
                  pick_word(), pick_word());
    endtask

    // result side: random stall bursts plus the long hold
    always @(negedge clk) begin : ready_gen
        static int hold_left = 0;
        static int stall_left = 0;
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk) begin : score_check
        score_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                $display("%0t: unexpected score transfer log_prob=%h unknown=%b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end
            else begin
                e = pending_scores.pop_front();
                if (m_tdata !== e.log_prob) begin
                    $display("%0t: log_prob expected %h actual %h", $time, e.log_prob, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== e.unknown) begin
                    $display("%0t: unknown_word expected %b actual %b",
                             $time, e.unknown, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_oov(24'h9C0000);                  // reset value, -100.0
        test_directed();
        wait_drained();
        set_oov(24'h800000);                  // most negative
        test_random(120);
        test_backpressure();
        wait_drained();
        set_oov(24'h000000);
        test_random(100);
        wait_drained();                       // sender pauses until all scores are back
        set_oov(24'($urandom_range(0, 8388607)) ^ 24'hFFFFFF);
        test_random(100);
        wait_drained();
        no_idle = 1;
        test_random(60);
        wait_drained();
        if (error_count == 0)
            $display("[double_array_ngram_backoff_lookup] OK");
        else
            $display("[double_array_ngram_backoff_lookup] ERROR");
        $finish;
    end

    // covers the post-reset clear of the whole trie
    initial begin
        #40_000_000;
        $display("[double_array_ngram_backoff_lookup] ERROR");
        $finish;
    end

endmodule
